### sv/hws_pkg.sv
// Package for the harmonic wavetable sum block: field widths, default sizes,
// request codes, sine table build constants and the multiply-accumulate control type.
// No dependencies.
`default_nettype none

package hws_pkg;

    // Field widths of the input and result beats.
    localparam int REQ_W    = 1;
    localparam int HNUM_W   = 7;
    localparam int LEVEL_W  = 16;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 7;
    localparam int SINE_W   = 16;
    localparam int PROD_W   = LEVEL_W + 1 + SINE_W;
    localparam int SAMPLE_W = 38;

    // Default sizes handed to the top level.
    localparam int WAVE_SIZE_DEF     = 1024;
    localparam int MAX_HARMONICS_DEF = 64;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 1'b0;
    localparam logic [REQ_W-1:0] REQ_READ  = 1'b1;

    // Sine table build: pi/2 in Q30, full scale of Q1.15 and the Taylor divisors (2m)(2m+1).
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          SINE_MAX     = 32767;
    localparam int          TAYLOR_TERMS = 7;
    localparam int          TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

### sv/harmonic_wavetable_sum.sv
// Harmonic wavetable sum. A write beat gives no result.
// A read beat with n = min(harmonic_count, WAVE_SIZE-1, MAX_HARMONICS) harmonics passes
// one harmonic per cycle through the single multiply-accumulate unit, then the table
// read, the product register and the result load; with n zero it goes straight to the
// result load, which waits while the output register holds an unaccepted result.
// Reset (rst_n low, asynchronous) clears every entry of the level store with in_ready
// low and sets harmonic_count to zero.
`default_nettype none

module harmonic_wavetable_sum #(
    parameter int WAVE_SIZE     = hws_pkg::WAVE_SIZE_DEF,
    parameter int MAX_HARMONICS = hws_pkg::MAX_HARMONICS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [hws_pkg::REQ_W-1:0]            req_type,
    input  wire logic [hws_pkg::HNUM_W-1:0]           harmonic_number,
    input  wire logic [hws_pkg::LEVEL_W-1:0]          level,
    input  wire logic [hws_pkg::INDEX_W-1:0]          sample_index,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [hws_pkg::SAMPLE_W-1:0]       sample_value,
    input  wire logic                                 cfg_write,
    input  wire logic [hws_pkg::COUNT_W-1:0]          cfg_data
);

    localparam int AW        = $clog2(WAVE_SIZE);
    localparam int LA        = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int KW        = $clog2(MAX_HARMONICS + 1);
    localparam int RW        = (AW > hws_pkg::INDEX_W) ? AW : hws_pkg::INDEX_W;
    localparam int INDEX_SPAN = 1 << hws_pkg::INDEX_W;
    localparam int RED_STEPS = $clog2((INDEX_SPAN + WAVE_SIZE - 1) / WAVE_SIZE);
    localparam int N_LIMIT   = (WAVE_SIZE - 1 < MAX_HARMONICS) ? WAVE_SIZE - 1 : MAX_HARMONICS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [hws_pkg::COUNT_W-1:0]         harmonic_count_reg;
    logic [AW-1:0]                       step_reg;
    logic [AW-1:0]                       step_next;
    logic [AW-1:0]                       addr_reg;
    logic [AW-1:0]                       addr_next;
    logic [KW-1:0]                       k_reg;
    logic [KW-1:0]                       k_next;
    logic [KW-1:0]                       n_reg;
    logic [KW-1:0]                       n_next;
    logic                                rd_v_reg;
    logic                                issue;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [hws_pkg::SAMPLE_W-1:0] sample_value_reg;
    logic                                load_out;
    logic                                accept;
    logic                                accept_read;
    logic                                hnum_ok;
    logic                                store_ready;
    logic [RW-1:0]                       red;
    logic [KW-1:0]                       n_clamped;
    logic [AW:0]                         addr_sum;
    logic [hws_pkg::LEVEL_W-1:0]         lvl_rd;
    logic signed [hws_pkg::SINE_W-1:0]   sine_rd;
    logic                                mac_busy;
    logic signed [hws_pkg::SAMPLE_W-1:0] mac_acc;
    hws_pkg::mac_ctrl_t                  mac_ctrl;

    assign in_ready    = (state_reg == ST_IDLE) && store_ready;
    assign accept      = in_valid && in_ready;
    assign accept_read = accept && (req_type == hws_pkg::REQ_READ);
    assign hnum_ok     = (harmonic_number != '0) && (32'(harmonic_number) <= MAX_HARMONICS);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harmonic_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            harmonic_count_reg <= cfg_data;
        end
    end

    // Reduce the sample index into the table by shifted compare and subtract.
    always_comb
    begin
        red = RW'(sample_index);
        for (int j = RED_STEPS - 1; j >= 0; j--)
        begin
            if (32'(red) >= (WAVE_SIZE << j))
            begin
                red = red - RW'(WAVE_SIZE << j);
            end
        end
    end

    // Number of harmonics that take part in a read.
    always_comb
    begin
        if (32'(harmonic_count_reg) > N_LIMIT)
        begin
            n_clamped = KW'(N_LIMIT);
        end
        else
        begin
            n_clamped = KW'(harmonic_count_reg);
        end
    end

    // Table address of the next harmonic: index times k modulo the table size.
    always_comb
    begin
        addr_sum = {1'b0, addr_reg} + {1'b0, step_reg};
        if (addr_sum >= (AW + 1)'(WAVE_SIZE))
        begin
            addr_sum = addr_sum - (AW + 1)'(WAVE_SIZE);
        end
    end

    // Sequencer: accept, one harmonic per cycle, then drain the pipeline.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        issue          = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_read)
                begin
                    step_next  = red[AW-1:0];
                    addr_next  = red[AW-1:0];
                    k_next     = KW'(1);
                    n_next     = n_clamped;
                    state_next = (n_clamped == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue     = 1'b1;
                addr_next = addr_sum[AW-1:0];
                k_next    = k_reg + KW'(1);
                if (k_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !mac_busy && (!out_valid_reg || out_ready))
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_v_reg      <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        addr_reg <= addr_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        if (load_out)
        begin
            sample_value_reg <= mac_acc;
        end
    end

    // Level store, table and multiply-accumulate unit.
    hws_level_store #(
        .MAX_HARMONICS (MAX_HARMONICS),
        .LA            (LA)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (req_type == hws_pkg::REQ_WRITE) && hnum_ok),
        .wr_addr (LA'(harmonic_number - hws_pkg::HNUM_W'(1))),
        .wr_data (level),
        .rd_addr (LA'(k_reg - KW'(1))),
        .rd_data (lvl_rd),
        .ready   (store_ready)
    );

    hws_sine_rom #(
        .WAVE_SIZE (WAVE_SIZE),
        .AW        (AW)
    ) u_rom (
        .clk  (clk),
        .addr (addr_reg),
        .data (sine_rd)
    );

    assign mac_ctrl.clear      = accept_read;
    assign mac_ctrl.data_valid = rd_v_reg;

    hws_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .level (lvl_rd),
        .sine  (sine_rd),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_value_reg;

endmodule

`default_nettype wire

### sv/hws_level_store.sv
// Harmonic level store: one write port, one registered read port, and a
// clearing pass after reset. Depends on hws_pkg.
`default_nettype none

module hws_level_store #(
    parameter int MAX_HARMONICS = hws_pkg::MAX_HARMONICS_DEF,
    parameter int LA            = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [LA-1:0]               wr_addr,
    input  wire logic [hws_pkg::LEVEL_W-1:0] wr_data,
    input  wire logic [LA-1:0]               rd_addr,
    output logic      [hws_pkg::LEVEL_W-1:0] rd_data,
    output logic                             ready
);

    logic [hws_pkg::LEVEL_W-1:0] mem [MAX_HARMONICS];
    logic [hws_pkg::LEVEL_W-1:0] rd_data_reg;
    logic                        clearing_reg;
    logic                        clearing_next;
    logic [LA-1:0]               clr_addr_reg;
    logic [LA-1:0]               clr_addr_next;
    logic                        mem_we;
    logic [LA-1:0]               mem_wa;
    logic [hws_pkg::LEVEL_W-1:0] mem_wd;

    // The clearing pass walks every entry once, writing zero.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == LA'(MAX_HARMONICS - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + LA'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Write port shared by the clearing pass and level writes.
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = wr_en;
            mem_wa = wr_addr;
            mem_wd = wr_data;
        end
    end

    // Storage array with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

`default_nettype wire

### sv/hws_sine_rom.sv
// Q1.15 sine table of one wave cycle, built at elaboration from a Taylor
// series in Q30, read with registered data. Depends on hws_pkg.
`default_nettype none

module hws_sine_rom #(
    parameter int WAVE_SIZE = hws_pkg::WAVE_SIZE_DEF,
    parameter int AW        = $clog2(WAVE_SIZE)
) (
    input  wire logic                              clk,
    input  wire logic [AW-1:0]                     addr,
    output logic signed [hws_pkg::SINE_W-1:0]      data
);

    typedef logic signed [hws_pkg::SINE_W-1:0] rom_t [WAVE_SIZE];

    // One entry per phase step: mirror by quadrant, series in Q30, scale and round.
    function automatic rom_t build_rom();
        rom_t               rom;
        logic [63:0]        phase;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] s;
        logic [1:0]         quad;
        for (int i = 0; i < WAVE_SIZE; i++)
        begin
            phase = (64'(i) << 32) / 64'(WAVE_SIZE);
            quad  = phase[31:30];
            r     = {34'd0, phase[29:0]};
            if (quad[0])
            begin
                r = (64'd1 << 30) - r;
            end
            x    = (r * hws_pkg::HALF_PI_Q30 + (64'd1 << 29)) >> 30;
            term = x;
            s    = $signed(x);
            for (int m = 1; m <= hws_pkg::TAYLOR_TERMS; m++)
            begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'(hws_pkg::TAYLOR_DIV[m-1]);
                if (m % 2 == 1)
                begin
                    s = s - $signed(term);
                end
                else
                begin
                    s = s + $signed(term);
                end
            end
            if (s < 0)
            begin
                s = '0;
            end
            prod = ($unsigned(s) * 64'(hws_pkg::SINE_MAX) + (64'd1 << 29)) >> 30;
            if (prod > 64'(hws_pkg::SINE_MAX))
            begin
                prod = 64'(hws_pkg::SINE_MAX);
            end
            rom[i] = quad[1] ? -(hws_pkg::SINE_W'(prod)) : hws_pkg::SINE_W'(prod);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [hws_pkg::SINE_W-1:0] data_reg;

    // Registered table read.
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### sv/hws_mac.sv
// Shared multiply-accumulate unit: one level times sine product per cycle,
// registered, then a saturating add into the 38-bit sum. Depends on hws_pkg.
`default_nettype none

module hws_mac (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hws_pkg::mac_ctrl_t                  ctrl,
    input  wire logic [hws_pkg::LEVEL_W-1:0]         level,
    input  wire logic signed [hws_pkg::SINE_W-1:0]   sine,
    output logic                                     busy,
    output logic signed [hws_pkg::SAMPLE_W-1:0]      acc
);

    logic signed [hws_pkg::PROD_W-1:0]   prod_reg;
    logic signed [hws_pkg::PROD_W-1:0]   prod_next;
    logic                                prod_v_reg;
    logic signed [hws_pkg::SAMPLE_W-1:0] acc_reg;
    logic signed [hws_pkg::SAMPLE_W-1:0] acc_next;
    logic signed [hws_pkg::SAMPLE_W:0]   sum_wide;

    // Product stage: the level is zero-extended so the multiply stays signed.
    assign prod_next = $signed({1'b0, level}) * sine;

    // Accumulate stage with saturation to the 38-bit signed range.
    always_comb
    begin
        sum_wide = (hws_pkg::SAMPLE_W + 1)'(acc_reg) + (hws_pkg::SAMPLE_W + 1)'(prod_reg);
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            if (sum_wide[hws_pkg::SAMPLE_W] != sum_wide[hws_pkg::SAMPLE_W-1])
            begin
                acc_next = sum_wide[hws_pkg::SAMPLE_W]
                         ? {1'b1, {(hws_pkg::SAMPLE_W-1){1'b0}}}
                         : {1'b0, {(hws_pkg::SAMPLE_W-1){1'b1}}};
            end
            else
            begin
                acc_next = sum_wide[hws_pkg::SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            prod_v_reg <= ctrl.data_valid && !ctrl.clear;
            acc_reg    <= acc_next;
        end
    end

    assign busy = prod_v_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

### verif/hws_sample_checker.sv
// Scoreboard for the harmonic wavetable sum block: watches the input, result and
// configuration ports, predicts each wave sample and compares it with the block's output.
// Depends on hws_pkg for field widths, request codes and default sizes.

module hws_sample_checker
    import hws_pkg::*;
#(
    parameter int WAVE_POINTS = WAVE_SIZE_DEF,
    parameter int HARM_SLOTS  = MAX_HARMONICS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [HNUM_W-1:0]          harmonic_number,
    input  logic [LEVEL_W-1:0]         level,
    input  logic [INDEX_W-1:0]         sample_index,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       cfg_write,
    input  logic [COUNT_W-1:0]         cfg_data,
    output int                         fail_count,
    output int                         pending_samples,
    output int                         checked_samples
);

    // Phase scale for the sine build: pi/2 in Q30.
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint      SUM_CEIL         = 64'sd137438953471;
    localparam longint      SUM_FLOOR        = -64'sd137438953472;

    shortint                   sine_q15 [WAVE_POINTS];
    logic [LEVEL_W-1:0]        level_store [HARM_SLOTS];
    logic [COUNT_W-1:0]        active_harmonics;
    logic signed [SAMPLE_W-1:0] sample_fifo [$];
    logic signed [SAMPLE_W-1:0] want;
    int                        fails_n;
    int                        checked_n;

    // One sine table entry, built from a Q30 quarter-turn Taylor series.
    function automatic shortint sine_point(input int unsigned pos);
        logic [63:0]        phase;
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        scaled;
        logic signed [63:0] acc;
        phase = (64'(pos) << 32) / 64'(WAVE_POINTS);
        quad  = phase[31:30];
        r     = {34'd0, phase[29:0]};
        if (quad[0])
            r = (64'd1 << 30) - r;
        x    = (r * QUARTER_TURN_Q30 + (64'd1 << 29)) >> 30;
        term = x;
        acc  = $signed(x);
        for (int m = 1; m <= 7; m++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * m) * (2 * m + 1));
            if (m % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 0;
        scaled = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (scaled > 64'd32767)
            scaled = 64'd32767;
        return quad[1] ? shortint'(-int'(scaled)) : shortint'(int'(scaled));
    endfunction

    // Sum of level times sine over the active harmonics, saturated to the result width.
    function automatic logic signed [SAMPLE_W-1:0] wave_value(input logic [INDEX_W-1:0] idx);
        int     n;
        int     addr;
        longint acc;
        n = int'(active_harmonics);
        if (n > WAVE_POINTS - 1)
            n = WAVE_POINTS - 1;
        if (n > HARM_SLOTS)
            n = HARM_SLOTS;
        acc = 0;
        for (int k = 1; k <= n; k++)
        begin
            if (level_store[k-1] != '0)
            begin
                addr = (int'(idx) * k) % WAVE_POINTS;
                acc  = acc + longint'(level_store[k-1]) * longint'(sine_q15[addr]);
                if (acc > SUM_CEIL)
                    acc = SUM_CEIL;
                if (acc < SUM_FLOOR)
                    acc = SUM_FLOOR;
            end
        end
        return acc[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i < WAVE_POINTS; i++)
            sine_q15[i] = sine_point(i);
    end

    // Track state on every beat; results are checked before new reads are queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < HARM_SLOTS; h++)
                level_store[h] = '0;
            active_harmonics = '0;
            sample_fifo.delete();
            fails_n   = 0;
            checked_n = 0;
            fail_count      <= 0;
            pending_samples <= 0;
            checked_samples <= 0;
        end
        else
        begin
            // Result beat: compare with the oldest outstanding read.
            if (out_valid && out_ready)
            begin
                if (sample_fifo.size() == 0)
                begin
                    $error("sample_value: result beat with no read outstanding, actual %0d",
                           sample_value);
                    fails_n++;
                end
                else
                begin
                    want = sample_fifo.pop_front();
                    checked_n++;
                    if (sample_value !== want)
                    begin
                        $error("sample_value mismatch: expected %0d, actual %0d",
                               want, sample_value);
                        fails_n++;
                    end
                end
            end

            if (cfg_write)
                active_harmonics = cfg_data;

            // Input beat: a write updates the level store, a read queues a sample.
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (harmonic_number >= 1 && int'(harmonic_number) <= HARM_SLOTS)
                        level_store[harmonic_number - 1] = level;
                end
                else
                    sample_fifo.push_back(wave_value(sample_index));
            end

            fail_count      <= fails_n;
            pending_samples <= sample_fifo.size();
            checked_samples <= checked_n;
        end
    end

endmodule

### verif/tb_harmonic_wavetable_sum.sv
// Testbench top for the harmonic wavetable sum block: clock, reset, bursty request
// stimulus, result back-pressure and the final verdict.
// Depends on hws_pkg, the block itself and hws_sample_checker.

module tb_harmonic_wavetable_sum;
    import hws_pkg::*;

    localparam int HARM_SLOTS  = MAX_HARMONICS_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 45;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 80;

    // Receiver back-pressure modes.
    localparam int RX_ALWAYS = 0;
    localparam int RX_MOSTLY = 1;
    localparam int RX_RARELY = 2;
    localparam int RX_BLOCKS = 3;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [REQ_W-1:0]           req_type;
    logic [HNUM_W-1:0]          harmonic_number;
    logic [LEVEL_W-1:0]         level;
    logic [INDEX_W-1:0]         sample_index;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       cfg_write;
    logic [COUNT_W-1:0]         cfg_data;

    int fail_count;
    int pending_samples;
    int checked_samples;

    int burst_left   = 0;
    int rx_mode      = RX_ALWAYS;
    int rx_left      = 0;
    int beats_sent   = 0;
    int reads_sent   = 0;
    int settings_n   = 0;
    int cycle_count  = 0;

    harmonic_wavetable_sum u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .harmonic_number (harmonic_number),
        .level           (level),
        .sample_index    (sample_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample_value    (sample_value),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data)
    );

    hws_sample_checker u_sample_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .harmonic_number (harmonic_number),
        .level           (level),
        .sample_index    (sample_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sample_value    (sample_value),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_samples (pending_samples),
        .checked_samples (checked_samples)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result back-pressure: each mode holds for a random stretch of cycles.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_ALWAYS, RX_BLOCKS);
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_ALWAYS: out_ready <= 1'b1;
            RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
            RX_RARELY: out_ready <= ($urandom_range(0, 9) < 2);
            default:
            begin
                if ($urandom_range(0, 11) == 0)
                    out_ready <= ~out_ready;
            end
        endcase
    end

    // Send one beat; a new burst may open with a gap of idle cycles.
    task automatic send_beat(input logic [REQ_W-1:0] rq, input logic [HNUM_W-1:0] hn,
                             input logic [LEVEL_W-1:0] lv, input logic [INDEX_W-1:0] ix);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 100);
            else
                burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= rq;
        harmonic_number <= hn;
        level           <= lv;
        sample_index    <= ix;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        if (rq == REQ_READ)
            reads_sent++;
    endtask

    // Change harmonic_count only once every outstanding sample has come back.
    task automatic set_harmonic_count(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_samples != 0);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_n++;
    endtask

    // Levels lean toward silence and full scale.
    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r < 3)
            return '1;
        return LEVEL_W'($urandom);
    endfunction

    // Indices lean toward the quarter points and the ends of the cycle.
    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return INDEX_W'(256 * $urandom_range(1, 3));
            3:       return INDEX_W'(1);
            default: return INDEX_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int top_h;
        int n_reads;
        int phase_beats;
        bit full_scale;
        logic [COUNT_W-1:0] count_value;

        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        req_type        <= REQ_WRITE;
        harmonic_number <= '0;
        level           <= '0;
        sample_index    <= '0;
        out_ready       <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: no harmonics summed, then the largest count with edge levels.
        set_harmonic_count('0);
        send_beat(REQ_READ, 7'd1, 16'hFFFF, 10'd5);
        send_beat(REQ_READ, 7'd64, 16'd0, 10'd1023);
        set_harmonic_count('1);
        send_beat(REQ_WRITE, 7'd1, 16'hFFFF, 10'd0);
        send_beat(REQ_WRITE, 7'd64, 16'hFFFF, 10'd1023);
        // Harmonic numbers outside the store must leave it untouched.
        send_beat(REQ_WRITE, 7'd0, 16'd4660, 10'd0);
        send_beat(REQ_WRITE, 7'd65, 16'd777, 10'd0);
        send_beat(REQ_WRITE, 7'd127, 16'hFFFF, 10'd0);
        send_beat(REQ_WRITE, 7'd3, 16'd1, 10'd0);
        send_beat(REQ_WRITE, 7'd2, 16'd0, 10'd0);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd0);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd256);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd512);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd768);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd1023);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd1);
        send_beat(REQ_READ, 7'd0, 16'd0, 10'd341);
        send_beat(REQ_WRITE, 7'd2, 16'h8000, 10'd0);
        send_beat(REQ_WRITE, 7'd64, 16'd0, 10'd0);
        send_beat(REQ_READ, 7'd127, 16'hFFFF, 10'd100);
        send_beat(REQ_READ, 7'd127, 16'hFFFF, 10'd1023);

        // Random phases, each under its own harmonic_count.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       count_value = 7'd64;
                1:       count_value = 7'd1;
                2:       count_value = COUNT_W'($urandom_range(2, 63));
                3:       count_value = 7'd0;
                4:       count_value = COUNT_W'($urandom_range(65, 126));
                default: count_value = 7'd127;
            endcase
            set_harmonic_count(count_value);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                if ($urandom_range(0, 9) < 2)
                begin
                    // Load a run of harmonics in order, then read the new wave.
                    top_h      = $urandom_range(8, HARM_SLOTS);
                    full_scale = ($urandom_range(0, 2) == 0);
                    n_reads    = $urandom_range(1, 4);
                    for (int h = 1; h <= top_h; h++)
                        send_beat(REQ_WRITE, HNUM_W'(h), full_scale ? '1 : pick_level(),
                                  INDEX_W'($urandom));
                    for (int r = 0; r < n_reads; r++)
                        send_beat(REQ_READ, HNUM_W'($urandom), LEVEL_W'($urandom),
                                  pick_index());
                    phase_beats += top_h + n_reads;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    send_beat(REQ_READ, HNUM_W'($urandom), LEVEL_W'($urandom), pick_index());
                    phase_beats++;
                end
                else
                begin
                    if ($urandom_range(0, 6) == 0)
                        top_h = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(65, 127);
                    else
                        top_h = $urandom_range(1, HARM_SLOTS);
                    send_beat(REQ_WRITE, HNUM_W'(top_h), pick_level(), INDEX_W'($urandom));
                    phase_beats++;
                end
            end
        end

        // Drain, then give a stray result time to show up.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_samples != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d beats (%0d reads, %0d level writes) across %0d harmonic_count settings.",
                 beats_sent, reads_sent, beats_sent - reads_sent, settings_n);
        $display("Compared %0d samples; %0d mismatches.", checked_samples, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run stopped after %0d cycles with %0d samples outstanding",
               cycle_count, pending_samples);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
